[src/pgnt_pkg.sv]
// ----------------------------------------------------------------------------
// pgnt_pkg: shared types and constants
// Widths, command codes, register indexes and table port structs used by the
// gradient noise block.
// ----------------------------------------------------------------------------
package pgnt_pkg;

  localparam int unsigned TableAw  = 8;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CoordW   = 24;
  localparam int unsigned GradW    = 16;
  localparam int unsigned PermW    = 8;
  localparam int unsigned MaxOct   = 8;
  localparam int unsigned OctW     = 4;
  localparam int unsigned MulW     = 20;
  localparam int unsigned ProdW    = 2 * MulW;

  typedef enum logic [1:0] {
    CmdEval     = 2'd0,
    CmdLoadGrad = 2'd1,
    CmdLoadPerm = 2'd2
  } cmd_e;

  typedef enum logic {
    CfgModeTurb = 1'b0,
    CfgOctCount = 1'b1
  } cfg_idx_e;

  // table write request
  typedef struct packed {
    logic                    grad_we;
    logic                    perm_we;
    logic [TableAw-1:0]      idx;
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic signed [GradW-1:0] gz;
    logic [PermW-1:0]        px;
    logic [PermW-1:0]        py;
    logic [PermW-1:0]        pz;
  } tbl_wr_t;

  // table read addresses
  typedef struct packed {
    logic [TableAw-1:0] ax;
    logic [TableAw-1:0] ay;
    logic [TableAw-1:0] az;
    logic [TableAw-1:0] grad_addr;
  } tbl_rd_t;

  // table read data
  typedef struct packed {
    logic [PermW-1:0]        px;
    logic [PermW-1:0]        py;
    logic [PermW-1:0]        pz;
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic signed [GradW-1:0] gz;
  } tbl_rdata_t;

endpackage

[src/pgnt_if.sv]
// ----------------------------------------------------------------------------
// pgnt channel interfaces
// Valid/ready channels for command items, result items and register writes.
// ----------------------------------------------------------------------------
interface pgnt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [7:0]         table_index;
  logic [23:0]        coord_x;
  logic [23:0]        coord_y;
  logic [23:0]        coord_z;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;
  logic signed [15:0] grad_z;
  logic [7:0]         perm_x_value;
  logic [7:0]         perm_y_value;
  logic [7:0]         perm_z_value;

  modport source (
    output valid, cmd, table_index, coord_x, coord_y, coord_z,
    output grad_x, grad_y, grad_z, perm_x_value, perm_y_value, perm_z_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, table_index, coord_x, coord_y, coord_z,
    input  grad_x, grad_y, grad_z, perm_x_value, perm_y_value, perm_z_value,
    output ready
  );
endinterface

interface pgnt_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;
  logic               saturated;

  modport source (output valid, noise_value, saturated, input ready);
  modport sink (input valid, noise_value, saturated, output ready);
endinterface

interface pgnt_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [3:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/pgnt_mul.sv]
// ----------------------------------------------------------------------------
// pgnt_mul: shared signed multiplier
// One signed multiply used by every multiplying step of the sequencer.
// ----------------------------------------------------------------------------
module pgnt_mul (
  input  logic signed [pgnt_pkg::MulW-1:0]  a_i,
  input  logic signed [pgnt_pkg::MulW-1:0]  b_i,
  output logic signed [pgnt_pkg::ProdW-1:0] prod_o
);
  import pgnt_pkg::*;

  logic signed [ProdW-1:0] a_ext;
  logic signed [ProdW-1:0] b_ext;

  assign a_ext  = ProdW'(a_i);
  assign b_ext  = ProdW'(b_i);
  assign prod_o = a_ext * b_ext;

endmodule

[src/pgnt_tables.sv]
// ----------------------------------------------------------------------------
// pgnt_tables: gradient and permutation memories
// Three permutation memories and one gradient memory, one write port each
// and registered read data.
// ----------------------------------------------------------------------------
module pgnt_tables (
  input  logic                 clk_i,
  input  pgnt_pkg::tbl_wr_t    wr_i,
  input  pgnt_pkg::tbl_rd_t    rd_i,
  output pgnt_pkg::tbl_rdata_t rdata_o
);
  import pgnt_pkg::*;

  localparam int unsigned Depth = 1 << TableAw;

  logic [PermW-1:0]     perm_x_mem [Depth];
  logic [PermW-1:0]     perm_y_mem [Depth];
  logic [PermW-1:0]     perm_z_mem [Depth];
  logic [3*GradW-1:0]   grad_mem   [Depth];
  logic [3*PermW-1:0]   perm_rd_q;
  logic [3*GradW-1:0]   grad_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.perm_we) begin
      perm_x_mem[wr_i.idx] <= wr_i.px;
      perm_y_mem[wr_i.idx] <= wr_i.py;
      perm_z_mem[wr_i.idx] <= wr_i.pz;
    end
    perm_rd_q <= {perm_x_mem[rd_i.ax], perm_y_mem[rd_i.ay], perm_z_mem[rd_i.az]};
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.grad_we) begin
      grad_mem[wr_i.idx] <= {wr_i.gx, wr_i.gy, wr_i.gz};
    end
    grad_rd_q <= grad_mem[rd_i.grad_addr];
  end

  assign rdata_o.px = perm_rd_q[3*PermW-1:2*PermW];
  assign rdata_o.py = perm_rd_q[2*PermW-1:PermW];
  assign rdata_o.pz = perm_rd_q[PermW-1:0];
  assign rdata_o.gx = grad_rd_q[3*GradW-1:2*GradW];
  assign rdata_o.gy = grad_rd_q[2*GradW-1:GradW];
  assign rdata_o.gz = grad_rd_q[GradW-1:0];

endmodule

[src/perlin_gradient_noise_turbulence.sv]
// ----------------------------------------------------------------------------
// perlin_gradient_noise_turbulence: gradient noise with turbulence
// Table loads and point evaluation on one command channel, noise result out.
// ----------------------------------------------------------------------------
// Load commands write one gradient entry or one entry of each permutation
// table in the cycle they are taken and give no result. An evaluate item
// occupies the block until its result is in the output register; ready stays
// low meanwhile. All multiplies run through one shared 20x20 signed
// multiplier, so the cost is set by its step count: each octave runs the
// three fade curves, then for each of the 8 lattice corners the table reads,
// two weight products, three dot-product terms and the weighted accumulate,
// and then closes the octave. An evaluate item runs n octaves, with n = 1 in
// noise mode and n = min(octave_count, 8) in turbulence mode (n = 0 runs no
// octave). The result waits in an output register, so a new item is taken
// while it is still pending. Table entries never loaded read as garbage.
// ----------------------------------------------------------------------------
module perlin_gradient_noise_turbulence (
  input  logic       clk_i,
  input  logic       rst_ni,
  pgnt_in_if.sink    in_i,
  pgnt_out_if.source out_o,
  pgnt_cfg_if.sink   cfg_i
);
  import pgnt_pkg::*;

  localparam int unsigned WtW    = FracBits + 1;       // weights up to 1.0
  localparam int unsigned OffW   = FracBits + 2;       // signed corner offset
  localparam int unsigned DsumW  = 35;                 // three g*o terms
  localparam int unsigned DotW   = DsumW - FracBits;
  localparam int unsigned AccW   = 40;                 // eight dot*w3 terms
  localparam int unsigned NoiseW = AccW - FracBits;
  localparam int unsigned TurbW  = 36;
  localparam logic [WtW-1:0] One = WtW'(1) << FracBits;
  localparam logic [OffW-1:0] ThreeOne = OffW'(3) << FracBits;
  localparam logic signed [TurbW-1:0] SatHi = TurbW'(32767);
  localparam logic signed [TurbW-1:0] SatLo = -TurbW'(32768);

  // sequencer states, one-hot
  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_FADE1 = 11'b000_0000_0010,
    S_FADE2 = 11'b000_0000_0100,
    S_PERM  = 11'b000_0000_1000,
    S_GRAD  = 11'b000_0001_0000,
    S_WXY   = 11'b000_0010_0000,
    S_W3    = 11'b000_0100_0000,
    S_GX    = 11'b000_1000_0000,
    S_GY    = 11'b001_0000_0000,
    S_GZ    = 11'b010_0000_0000,
    S_DOT   = 11'b100_0000_0000
  } state_e;

  // octave close and finish run in S_IDLE via the flags below
  state_e state_q, state_d;
  logic   oct_end_q, oct_end_d;          // close octave this cycle
  logic   fin_q, fin_d;                  // result waiting to be loaded

  // configuration registers
  logic            mode_turb_q;
  logic [OctW-1:0] oct_count_q;

  // working registers
  logic [CoordW-1:0]       coord_q [3];
  logic [WtW-1:0]          fade_q  [3];
  logic [FracBits-1:0]     s_q;
  logic [1:0]              axis_q;
  logic [2:0]              corner_q;
  logic [WtW-1:0]          t_q;
  logic [WtW-1:0]          w3_q;
  logic signed [DsumW-1:0] dsum_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [TurbW-1:0] turb_q;
  logic signed [NoiseW-1:0] noise_q;
  logic [OctW-1:0]         oct_q;
  logic [OctW-1:0]         nocts_q;

  // output register
  logic               out_valid_q;
  logic signed [15:0] out_noise_q;
  logic               out_sat_q;

  // table port
  tbl_wr_t    tbl_wr;
  tbl_rd_t    tbl_rd;
  tbl_rdata_t tbl_rdata;

  // shared multiplier
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod;

  logic                in_acc;
  logic                is_eval;
  logic [FracBits-1:0] u_sel;
  logic                di, dj, dk;
  logic [WtW-1:0]      wx, wy, wz;
  logic signed [OffW-1:0] ox, oy, oz;
  logic [OctW-1:0]     n_eff;
  logic signed [TurbW-1:0] turb_abs;
  logic signed [TurbW-1:0] res_wide;
  logic                out_free;

  assign in_i.ready  = (state_q == S_IDLE) && !oct_end_q && !fin_q;
  assign in_acc      = in_i.valid && in_i.ready;
  assign is_eval     = cmd_e'(in_i.cmd) == CmdEval;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;

  assign n_eff = (oct_count_q > OctW'(MaxOct)) ? OctW'(MaxOct) : oct_count_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_turb_q <= 1'b1;
      oct_count_q <= OctW'(7);
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgModeTurb: mode_turb_q <= cfg_i.data[0];
        CfgOctCount: oct_count_q <= cfg_i.data;
        default:     mode_turb_q <= mode_turb_q;
      endcase
    end
  end

  // table writes straight from the command item
  always_comb begin
    tbl_wr.grad_we = in_acc && (cmd_e'(in_i.cmd) == CmdLoadGrad);
    tbl_wr.perm_we = in_acc && (cmd_e'(in_i.cmd) == CmdLoadPerm);
    tbl_wr.idx     = in_i.table_index;
    tbl_wr.gx      = in_i.grad_x;
    tbl_wr.gy      = in_i.grad_y;
    tbl_wr.gz      = in_i.grad_z;
    tbl_wr.px      = in_i.perm_x_value;
    tbl_wr.py      = in_i.perm_y_value;
    tbl_wr.pz      = in_i.perm_z_value;
  end

  // corner selection: bit 2 is x, bit 1 is y, bit 0 is z
  assign di = corner_q[2];
  assign dj = corner_q[1];
  assign dk = corner_q[0];

  // lattice corner addresses, hash of the registered permutation entries
  always_comb begin
    tbl_rd.ax        = coord_q[0][CoordW-1:FracBits] + TableAw'(di);
    tbl_rd.ay        = coord_q[1][CoordW-1:FracBits] + TableAw'(dj);
    tbl_rd.az        = coord_q[2][CoordW-1:FracBits] + TableAw'(dk);
    tbl_rd.grad_addr = tbl_rdata.px ^ tbl_rdata.py ^ tbl_rdata.pz;
  end

  pgnt_tables u_tables (
    .clk_i   (clk_i),
    .wr_i    (tbl_wr),
    .rd_i    (tbl_rd),
    .rdata_o (tbl_rdata)
  );

  // fade weights and corner offsets
  assign u_sel = coord_q[axis_q][FracBits-1:0];
  assign wx = di ? fade_q[0] : One - fade_q[0];
  assign wy = dj ? fade_q[1] : One - fade_q[1];
  assign wz = dk ? fade_q[2] : One - fade_q[2];
  assign ox = $signed({2'b00, coord_q[0][FracBits-1:0]}) - (di ? $signed(OffW'(One)) : '0);
  assign oy = $signed({2'b00, coord_q[1][FracBits-1:0]}) - (dj ? $signed(OffW'(One)) : '0);
  assign oz = $signed({2'b00, coord_q[2][FracBits-1:0]}) - (dk ? $signed(OffW'(One)) : '0);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_FADE1: begin
        mul_a = $signed(MulW'(u_sel));
        mul_b = $signed(MulW'(u_sel));
      end
      S_FADE2: begin
        mul_a = $signed(MulW'(s_q));
        mul_b = $signed(MulW'(ThreeOne - {1'b0, u_sel, 1'b0}));
      end
      S_WXY: begin
        mul_a = $signed(MulW'(wx));
        mul_b = $signed(MulW'(wy));
      end
      S_W3: begin
        mul_a = $signed(MulW'(t_q));
        mul_b = $signed(MulW'(wz));
      end
      S_GX: begin
        mul_a = MulW'(tbl_rdata.gx);
        mul_b = MulW'(ox);
      end
      S_GY: begin
        mul_a = MulW'(tbl_rdata.gy);
        mul_b = MulW'(oy);
      end
      S_GZ: begin
        mul_a = MulW'(tbl_rdata.gz);
        mul_b = MulW'(oz);
      end
      S_DOT: begin
        // floor of the dot sum
        mul_a = MulW'($signed(dsum_q[FracBits+DotW-1:FracBits]));
        mul_b = $signed(MulW'(w3_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pgnt_mul u_mul (
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // final value: raw noise, or turbulence magnitude scaled back
  assign turb_abs = (turb_q < 0) ? -turb_q : turb_q;
  assign res_wide = mode_turb_q ? (turb_abs >>> MaxOct) : TurbW'(noise_q);

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    oct_end_d = 1'b0;
    fin_d     = fin_q;
    unique case (state_q)
      S_IDLE: begin
        if (oct_end_q) begin
          if (!mode_turb_q || (oct_q + OctW'(1)) >= nocts_q) begin
            fin_d = 1'b1;
          end else begin
            state_d = S_FADE1;
          end
        end else if (fin_q) begin
          if (out_free) fin_d = 1'b0;
        end else if (in_acc && is_eval) begin
          if (mode_turb_q && n_eff == '0) fin_d = 1'b1;
          else state_d = S_FADE1;
        end
      end
      S_FADE1: state_d = S_FADE2;
      S_FADE2: state_d = (axis_q == 2'd2) ? S_PERM : S_FADE1;
      S_PERM:  state_d = S_GRAD;
      S_GRAD:  state_d = S_WXY;
      S_WXY:   state_d = S_W3;
      S_W3:    state_d = S_GX;
      S_GX:    state_d = S_GY;
      S_GY:    state_d = S_GZ;
      S_GZ:    state_d = S_DOT;
      S_DOT: begin
        if (corner_q == 3'd7) begin
          state_d   = S_IDLE;
          oct_end_d = 1'b1;
        end else begin
          state_d = S_PERM;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      oct_end_q <= 1'b0;
      fin_q     <= 1'b0;
      axis_q    <= '0;
      corner_q  <= '0;
      oct_q     <= '0;
    end else begin
      state_q   <= state_d;
      oct_end_q <= oct_end_d;
      fin_q     <= fin_d;
      if (in_acc) begin
        axis_q   <= '0;
        corner_q <= '0;
        oct_q    <= '0;
      end
      if (state_q == S_FADE2) begin
        axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
      end
      if (state_q == S_DOT) corner_q <= corner_q + 3'd1;
      if (oct_end_q) oct_q <= oct_q + OctW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      coord_q[0] <= in_i.coord_x;
      coord_q[1] <= in_i.coord_y;
      coord_q[2] <= in_i.coord_z;
      acc_q      <= '0;
      turb_q     <= '0;
      nocts_q    <= n_eff;
    end
    unique case (state_q)
      S_FADE1: s_q <= prod[2*FracBits-1:FracBits];
      S_FADE2: fade_q[axis_q] <= prod[2*FracBits:FracBits];
      S_WXY:   t_q <= prod[2*FracBits:FracBits];
      S_W3:    w3_q <= prod[2*FracBits:FracBits];
      S_GX:    dsum_q <= DsumW'(prod);
      S_GY:    dsum_q <= dsum_q + DsumW'(prod);
      S_GZ:    dsum_q <= dsum_q + DsumW'(prod);
      S_DOT:   acc_q <= acc_q + AccW'(prod);
      default: ;
    endcase
    if (oct_end_q) begin
      noise_q    <= acc_q[AccW-1:FracBits];
      turb_q     <= turb_q + (TurbW'($signed(acc_q[AccW-1:FracBits]))
                              <<< (OctW'(MaxOct) - oct_q));
      acc_q      <= '0;
      coord_q[0] <= {coord_q[0][CoordW-2:0], 1'b0};
      coord_q[1] <= {coord_q[1][CoordW-2:0], 1'b0};
      coord_q[2] <= {coord_q[2][CoordW-2:0], 1'b0};
    end
  end

  // output register, loaded when the result is ready and the slot is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_q && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q && out_free) begin
      priority if (res_wide > SatHi) begin
        out_noise_q <= 16'sh7fff;
        out_sat_q   <= 1'b1;
      end else if (res_wide < SatLo) begin
        out_noise_q <= -16'sh8000;
        out_sat_q   <= 1'b1;
      end else begin
        out_noise_q <= res_wide[15:0];
        out_sat_q   <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.noise_value = out_noise_q;
  assign out_o.saturated   = out_sat_q;

  // the corner walk wraps back to the first corner when an octave closes
  a_corner_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oct_end_q |-> corner_q == 3'd0)
    else $error("corner counter not wrapped at octave end");

  // octave count never runs past the maximum
  a_oct_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oct_q <= OctW'(MaxOct))
    else $error("octave counter out of range");

  // a new result only appears after a finished evaluation
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fin_q))
    else $error("result without evaluation");

  // a clipped result sits at one of the range limits
  a_sat_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_sat_q) |->
      (out_noise_q == 16'sh7fff || out_noise_q == -16'sh8000))
    else $error("saturated flag with in-range value");

endmodule
